[design/mtdl_pkg.sv]
package mtdl_pkg;

   // Field widths of one request and one result
   localparam int SAMPLE_W    = 24;
   localparam int GAIN_W      = 16;
   localparam int DELAY_W     = 13;
   localparam int INDEX_W     = 5;
   localparam int COUNT_REG_W = 6;
   localparam int LEN_REG_W   = 13;
   localparam int PROD_W      = SAMPLE_W + GAIN_W;
   localparam int REQ_DATA_W  = 64;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;

   // Q3.37 sum back to Q1.23: add half an LSB, then arithmetic shift
   localparam int FRAC_SHIFT  = 14;
   localparam int ROUND_HALF  = 8192;
   localparam int SAMPLE_MAX  = 8388607;
   localparam int SAMPLE_MIN  = -8388608;

   // Request kinds carried in req_tuser
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_TAPS    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Where the sample for one tap comes from
   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_INPUT,
      SRC_STORE
   } src_type;

endpackage

[design/multi_tap_delay_line.sv]
// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+---------------------------------------------
// req       | in  | req_tvalid/req_tready  | tuser: cmd; tdata: sample_in, tap_index,
//           |     |                        |        tap_delay, tap_gain
// rsp       | out | rsp_tvalid/rsp_tready  | tdata: sample_out
// csr       | in  | csr_valid/csr_ready    | csr_index, csr_data (num_taps, line_length)
//
// A load request gives no response.
// A sample request with N active taps (the tap register clamped to MAX_TAPS)
// holds the block until its response is committed; the request side reopens in
// the same cycle as the response is raised. One shared 24x16 multiplier and one
// accumulator take one tap per cycle behind a store-read, multiply, accumulate
// pipe, then drain and commit.
// Reset is synchronous; the history store needs no clearing pass because a
// fill mark makes never-written entries read as zero.
// A stalled response holds the block in its commit cycle; one finished
// response may wait in the output register while the next request is taken.
module multi_tap_delay_line #(
   parameter int MAX_TAPS   = 32,
   parameter int LINE_DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [23:0] sample_in, [28:24] tap_index, [41:29] tap_delay, [57:42] tap_gain
   input  logic [mtdl_pkg::REQ_DATA_W-1:0]        req_tdata,
   // [0] cmd
   input  logic [0:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [23:0] sample_out
   output logic [mtdl_pkg::SAMPLE_W-1:0]          rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mtdl_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mtdl_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int ACC_W  = mtdl_pkg::PROD_W + CNT_W;

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(mtdl_pkg::SAMPLE_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(mtdl_pkg::SAMPLE_MIN);

   // Request fields
   logic                                   req_cmd;
   logic signed [mtdl_pkg::SAMPLE_W-1:0]   req_sample;
   logic [mtdl_pkg::INDEX_W-1:0]           req_index;
   logic [mtdl_pkg::DELAY_W-1:0]           req_delay;
   logic signed [mtdl_pkg::GAIN_W-1:0]     req_gain;

   assign req_cmd    = req_tuser[0];
   assign req_sample = req_tdata[23:0];
   assign req_index  = req_tdata[28:24];
   assign req_delay  = req_tdata[41:29];
   assign req_gain   = req_tdata[57:42];

   // Control state
   mtdl_pkg::state_type state_ff, state_in;
   logic [mtdl_pkg::COUNT_REG_W-1:0] num_taps_ff, num_taps_in;
   logic [mtdl_pkg::LEN_REG_W-1:0]   line_length_ff, line_length_in;
   logic [ADDR_W-1:0]                wp_ff, wp_in;
   logic [LEN_W-1:0]                 fill_ff, fill_in;
   logic [CNT_W-1:0]                 tap_ff, tap_in;
   logic                             s1_valid_ff, s1_valid_in;
   logic                             s2_valid_ff, s2_valid_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic signed [mtdl_pkg::SAMPLE_W-1:0] x_ff;
   mtdl_pkg::src_type                    s1_src_ff, s1_src_in;
   logic signed [mtdl_pkg::GAIN_W-1:0]   s1_gain_ff;
   logic signed [mtdl_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic signed [mtdl_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]              acc_ff, acc_in;
   logic [mtdl_pkg::SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;

   // Tap table and history store
   logic [mtdl_pkg::DELAY_W-1:0]         delay_ff [MAX_TAPS];
   logic signed [mtdl_pkg::GAIN_W-1:0]   gain_ff  [MAX_TAPS];
   logic signed [mtdl_pkg::SAMPLE_W-1:0] mem      [LINE_DEPTH];

   logic req_fire, sample_fire, load_fire, issue, commit, mem_we;
   logic [LEN_W-1:0]   len;
   logic [CNT_W-1:0]   count;
   logic [ADDR_W-1:0]  wp_eff;
   logic [LEN_W-1:0]   wp_next;
   logic [mtdl_pkg::DELAY_W-1:0] cur_delay;
   logic [LEN_W:0]     diff;
   logic [ADDR_W-1:0]  rd_addr;
   logic signed [mtdl_pkg::SAMPLE_W-1:0] s2_sample;
   logic signed [ACC_W-1:0] rounded;
   logic signed [ACC_W-1:0] shifted;

   assign req_tready = (state_ff == mtdl_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign req_fire    = req_tvalid && req_tready;
   assign sample_fire = req_fire && (req_cmd == mtdl_pkg::CMD_SAMPLE);
   assign load_fire   = req_fire && (req_cmd == mtdl_pkg::CMD_LOAD);

   // Clamp the registers to what the hardware holds
   always_comb begin
      if (32'(line_length_ff) > 32'(LINE_DEPTH)) begin
         len = LEN_W'(LINE_DEPTH);
      end else begin
         len = LEN_W'(line_length_ff);
      end
      if (32'(num_taps_ff) > 32'(MAX_TAPS)) begin
         count = CNT_W'(MAX_TAPS);
      end else begin
         count = CNT_W'(num_taps_ff);
      end
      if ((len == '0) || (LEN_W'(wp_ff) >= len)) begin
         wp_eff = '0;
      end else begin
         wp_eff = wp_ff;
      end
   end

   assign issue     = (state_ff == mtdl_pkg::ST_RUN) && (tap_ff != count);
   assign cur_delay = delay_ff[tap_ff[TAP_W-1:0]];

   // Stage 1: sample at delay d is (wp - d) mod len, wp if d >= len, the input if d = 0
   always_comb begin
      diff    = (LEN_W+1)'(wp_eff) - (LEN_W+1)'(cur_delay);
      if (diff[LEN_W]) begin
         diff = diff + (LEN_W+1)'(len);
      end
      if (32'(cur_delay) >= 32'(len)) begin
         rd_addr = wp_eff;
      end else begin
         rd_addr = ADDR_W'(diff);
      end
      if (cur_delay == '0) begin
         s1_src_in = mtdl_pkg::SRC_INPUT;
      end else if (len == '0) begin
         s1_src_in = mtdl_pkg::SRC_ZERO;
      end else if (32'(rd_addr) < 32'(fill_ff)) begin
         s1_src_in = mtdl_pkg::SRC_STORE;
      end else begin
         // never written since reset: reads as zero
         s1_src_in = mtdl_pkg::SRC_ZERO;
      end
   end

   // Stage 2: one shared multiplier
   always_comb begin
      case (s1_src_ff)
         mtdl_pkg::SRC_INPUT: s2_sample = x_ff;
         mtdl_pkg::SRC_STORE: s2_sample = rd_data_ff;
         default:             s2_sample = '0;
      endcase
      prod_in = s2_sample * s1_gain_ff;
   end

   // Round half up to Q1.23 and saturate
   always_comb begin
      rounded = acc_ff + ACC_W'(mtdl_pkg::ROUND_HALF);
      shifted = rounded >>> mtdl_pkg::FRAC_SHIFT;
      if (shifted > SAT_HI) begin
         rsp_data_in = mtdl_pkg::SAMPLE_W'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         rsp_data_in = mtdl_pkg::SAMPLE_W'(SAT_LO);
      end else begin
         rsp_data_in = mtdl_pkg::SAMPLE_W'(shifted);
      end
   end

   // Sequencer: next state and control
   always_comb begin
      state_in       = state_ff;
      commit         = 1'b0;
      tap_in         = tap_ff;
      s1_valid_in    = issue;
      s2_valid_in    = s1_valid_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff;
      num_taps_in    = num_taps_ff;
      line_length_in = line_length_ff;
      wp_in          = wp_ff;
      fill_in        = fill_ff;
      wp_next        = LEN_W'(wp_eff) + LEN_W'(1);
      mem_we         = 1'b0;

      unique case (state_ff)
         mtdl_pkg::ST_IDLE: begin
            if (sample_fire) begin
               state_in = mtdl_pkg::ST_RUN;
               tap_in   = '0;
               acc_in   = '0;
            end
         end
         mtdl_pkg::ST_RUN: begin
            if (issue) begin
               tap_in = tap_ff + CNT_W'(1);
            end else begin
               state_in = mtdl_pkg::ST_DRAIN;
            end
         end
         mtdl_pkg::ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = mtdl_pkg::ST_DONE;
            end
         end
         mtdl_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = mtdl_pkg::ST_IDLE;
               commit   = 1'b1;
            end
         end
         default: state_in = mtdl_pkg::ST_IDLE;
      endcase

      if (s2_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Store the input and advance the write pointer
      if (commit && (len != '0)) begin
         mem_we = 1'b1;
         if (wp_next >= len) begin
            wp_in = '0;
         end else begin
            wp_in = ADDR_W'(wp_next);
         end
         if (wp_next > fill_ff) begin
            fill_in = wp_next;
         end
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mtdl_pkg::CSR_NUM_TAPS: begin
               num_taps_in = mtdl_pkg::COUNT_REG_W'(csr_data);
            end
            mtdl_pkg::CSR_LINE_LENGTH: begin
               line_length_in = csr_data;
               wp_in          = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mtdl_pkg::ST_IDLE;
         num_taps_ff    <= '0;
         line_length_ff <= '0;
         wp_ff          <= '0;
         fill_ff        <= '0;
         tap_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         num_taps_ff    <= num_taps_in;
         line_length_ff <= line_length_in;
         wp_ff          <= wp_in;
         fill_ff        <= fill_in;
         tap_ff         <= tap_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (sample_fire) begin
         x_ff <= req_sample;
      end
      s1_src_ff  <= s1_src_in;
      s1_gain_ff <= gain_ff[tap_ff[TAP_W-1:0]];
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Tap table: drop loads to entries beyond MAX_TAPS
   always_ff @(posedge clock) begin
      if (load_fire && (32'(req_index) < 32'(MAX_TAPS))) begin
         delay_ff[TAP_W'(req_index)] <= req_delay;
         gain_ff[TAP_W'(req_index)]  <= req_gain;
      end
   end

   // History store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_eff] <= x_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // A sample request closes the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      sample_fire |=> !req_tready)
      else $error("request side open while a sample is in work");

   // Writes fill the store from address zero, so the pointer never passes the fill mark
   assert property (@(posedge clock) disable iff (reset)
      LEN_W'(wp_ff) <= fill_ff)
      else $error("write pointer beyond fill mark");

   // The multiply stage only carries taps while a sample is in work
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (state_ff == mtdl_pkg::ST_RUN) || (state_ff == mtdl_pkg::ST_DRAIN))
      else $error("tap in pipe outside sample work");

   // A response appears only from the commit cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == mtdl_pkg::ST_DONE)
      else $error("response raised outside commit");

endmodule

[tb/multi_tap_delay_line_test.sv]
`timescale 1ns / 1ps

module multi_tap_delay_line_test;

   localparam int MAX_TAPS   = 32;
   localparam int LINE_DEPTH = 4096;
   localparam int IDLE_PCT   = 21;
   // Cycles after the last response in which a load may still be in flight
   localparam int HOLD_OFF   = 8;
   // A sample request with 32 taps is the longest; give the tail some margin
   localparam int TAIL       = 48;
   localparam int STALL_LIMIT = 5000;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [mtdl_pkg::REQ_DATA_W-1:0]       req_tdata = '0;
   logic [0:0]                            req_tuser = mtdl_pkg::CMD_SAMPLE;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [mtdl_pkg::SAMPLE_W-1:0]         rsp_tdata;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [mtdl_pkg::CSR_INDEX_W-1:0]      csr_index = mtdl_pkg::CSR_NUM_TAPS;
   logic [mtdl_pkg::CSR_DATA_W-1:0]       csr_data = '0;

   multi_tap_delay_line #(
      .MAX_TAPS   (MAX_TAPS),
      .LINE_DEPTH (LINE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Shadow of the block: history store, write pointer, tap table, registers
   logic signed [mtdl_pkg::SAMPLE_W-1:0] line_mem [LINE_DEPTH];
   int unsigned                          wr_pos;
   logic [mtdl_pkg::DELAY_W-1:0]         tap_dly [MAX_TAPS];
   logic signed [mtdl_pkg::GAIN_W-1:0]   tap_gn [MAX_TAPS];
   int unsigned                          cfg_taps;
   int unsigned                          cfg_len;

   // Mixed samples still owed by the block, oldest first
   logic signed [mtdl_pkg::SAMPLE_W-1:0] pending_mix [$];
   int                                   failures = 0;
   // Drop all idling on both sides while set
   bit                                   steady = 1'b0;

   // Weighted sum over the active taps for one input sample, then store it
   function automatic logic signed [mtdl_pkg::SAMPLE_W-1:0] mix_reflections(
      input logic signed [mtdl_pkg::SAMPLE_W-1:0] x);
      int unsigned len, cnt, pos, d, i;
      longint acc, r;
      logic signed [mtdl_pkg::SAMPLE_W-1:0] s;
      bit hit;
      len = (cfg_len > LINE_DEPTH) ? LINE_DEPTH : cfg_len;
      cnt = (cfg_taps > MAX_TAPS) ? MAX_TAPS : cfg_taps;
      pos = (len == 0 || wr_pos >= len) ? 0 : wr_pos;
      acc = 0;
      for (i = 0; i < cnt; i++) begin
         d = tap_dly[i];
         hit = 1'b1;
         if (d == 0) begin
            s = x;
         end else if (len == 0) begin
            hit = 1'b0;
            s = '0;
         end else if (d >= len) begin
            // clamp to the oldest stored sample
            s = line_mem[pos];
         end else begin
            s = line_mem[(pos + len - d) % len];
         end
         if (hit) acc += longint'(s) * longint'(tap_gn[i]);
      end
      // round half up back to Q1.23, then saturate
      r = (acc + mtdl_pkg::ROUND_HALF) >>> mtdl_pkg::FRAC_SHIFT;
      if (r > mtdl_pkg::SAMPLE_MAX) r = mtdl_pkg::SAMPLE_MAX;
      if (r < mtdl_pkg::SAMPLE_MIN) r = mtdl_pkg::SAMPLE_MIN;
      if (len != 0) begin
         line_mem[pos] = x;
         pos++;
         if (pos >= len) pos = 0;
         wr_pos = pos;
      end
      return mtdl_pkg::SAMPLE_W'(r);
   endfunction

   // Compare each response taken by the testbench with the oldest mix owed
   always @(posedge clock) begin
      logic signed [mtdl_pkg::SAMPLE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_mix.size() == 0) begin
            $error("sample_out: response with none expected, actual %0d",
                   $signed(rsp_tdata));
            failures++;
         end else begin
            want = pending_mix.pop_front();
            if (rsp_tdata !== want) begin
               $error("sample_out mismatch: expected %0d actual %0d",
                      want, $signed(rsp_tdata));
               failures++;
            end
         end
      end
   end

   // Stall the response side at random, except during the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // End the run if nothing moves on any channel for too long
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Offer one request and hold it until taken; valid stays high on return
   // unless a gap was drawn, so the next request can follow back to back.
   task automatic send_request(input logic cmd,
                               input logic signed [mtdl_pkg::SAMPLE_W-1:0] smp,
                               input logic [mtdl_pkg::INDEX_W-1:0] idx,
                               input logic [mtdl_pkg::DELAY_W-1:0] dly,
                               input logic signed [mtdl_pkg::GAIN_W-1:0] gn);
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, gn, dly, idx, smp};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (cmd == mtdl_pkg::CMD_LOAD) begin
         tap_dly[idx] = dly;
         tap_gn[idx]  = gn;
      end else begin
         pending_mix.push_back(mix_reflections(smp));
      end
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < IDLE_PCT);
      end
   endtask

   // Drop valid, wait for every owed response, then let a trailing load finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic write_csr(input logic [mtdl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [mtdl_pkg::CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == mtdl_pkg::CSR_NUM_TAPS) begin
         cfg_taps = value[mtdl_pkg::COUNT_REG_W-1:0];
      end else begin
         // a new length restarts the write pointer, contents stay
         cfg_len = value;
         wr_pos  = 0;
      end
   endtask

   // Write both registers back to back; only call with the block idle
   task automatic set_config(input int unsigned taps, input int unsigned len);
      settle();
      write_csr(mtdl_pkg::CSR_NUM_TAPS, mtdl_pkg::CSR_DATA_W'(taps));
      write_csr(mtdl_pkg::CSR_LINE_LENGTH, mtdl_pkg::CSR_DATA_W'(len));
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [mtdl_pkg::SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0:       return mtdl_pkg::SAMPLE_W'(mtdl_pkg::SAMPLE_MAX);
         1:       return mtdl_pkg::SAMPLE_W'(mtdl_pkg::SAMPLE_MIN);
         default: return mtdl_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [mtdl_pkg::GAIN_W-1:0] rand_gain();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         default: return mtdl_pkg::GAIN_W'($urandom);
      endcase
   endfunction

   // Favor delays that land inside the current line, keep some clamped ones
   function automatic logic [mtdl_pkg::DELAY_W-1:0] rand_delay();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 2) return '0;
      if (pick < 4) return mtdl_pkg::DELAY_W'(cfg_len);
      if (pick < 15 && cfg_len > 0)
         return mtdl_pkg::DELAY_W'($urandom_range(1, (cfg_len > 100) ? 100 : cfg_len));
      return mtdl_pkg::DELAY_W'($urandom_range(0, 8191));
   endfunction

   // Taps idle after reset: every mix must be zero
   task automatic test_after_reset();
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh7FFFFF, '0, '0, '0);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh800000, '0, '0, '0);
   endtask

   // Full-scale samples and gains, zero delay, delay equal to the length,
   // clamped delay, zero length, and a length rewrite over kept contents
   task automatic test_directed();
      send_request(mtdl_pkg::CMD_LOAD, '0, 5'd0, 13'd0, 16'sh7FFF);
      send_request(mtdl_pkg::CMD_LOAD, '0, 5'd1, 13'd1, 16'sh8000);
      send_request(mtdl_pkg::CMD_LOAD, '0, 5'd2, 13'd3, 16'sh4000);
      send_request(mtdl_pkg::CMD_LOAD, '1, 5'd31, 13'd8191, 16'shFFFF);
      send_request(mtdl_pkg::CMD_LOAD, '0, 5'd3, 13'd8191, 16'shFFFF);
      set_config(4, 3);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh7FFFFF, '0, '0, '0);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh800000, '1, '1, '1);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh7FFFFF, '0, '0, '0);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh800000, '0, '0, '0);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh000000, '0, '0, '0);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh000001, '0, '0, '0);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'shFFFFFF, '0, '0, '0);
      // zero length: only the zero-delay tap counts, nothing is stored
      set_config(4, 0);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh123456, '0, '0, '0);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'shABCDEF, '0, '0, '0);
      // shorter length over the old contents
      set_config(4, 2);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'sh400000, '0, '0, '0);
      send_request(mtdl_pkg::CMD_SAMPLE, 24'shC00000, '0, '0, '0);
   endtask

   // Fill the whole tap table, then run phases of mixed samples and loads
   // under a range of settings, extremes first
   task automatic test_random_phases();
      int unsigned taps_plan [6] = '{32, 63, 1, 0, 5, 32};
      int unsigned len_plan [6]  = '{4096, 0, 1, 8191, 2, 17};
      int unsigned phase, k, taps, len, pause_at;
      int i;
      for (i = 0; i < MAX_TAPS; i++)
         send_request(mtdl_pkg::CMD_LOAD, rand_sample(), mtdl_pkg::INDEX_W'(i),
                      rand_delay(), rand_gain());
      for (phase = 0; phase < 21; phase++) begin
         if (phase < 6) begin
            taps = taps_plan[phase];
            len  = len_plan[phase];
         end else begin
            taps = $urandom_range(0, 63);
            case ($urandom_range(0, 7))
               0:       len = $urandom_range(0, 8191);
               1:       len = $urandom_range(100, 600);
               default: len = $urandom_range(1, 64);
            endcase
         end
         set_config(taps, len);
         // no idling on either side for one whole phase
         steady = (phase == 7);
         pause_at = $urandom_range(10, 80);
         for (k = 0; k < 90; k++) begin
            if (k == pause_at) settle();
            if ($urandom_range(0, 99) < 12)
               send_request(mtdl_pkg::CMD_LOAD, rand_sample(),
                            mtdl_pkg::INDEX_W'($urandom), rand_delay(), rand_gain());
            else
               send_request(mtdl_pkg::CMD_SAMPLE, rand_sample(),
                            mtdl_pkg::INDEX_W'($urandom), mtdl_pkg::DELAY_W'($urandom),
                            mtdl_pkg::GAIN_W'($urandom));
         end
         steady = 1'b0;
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < LINE_DEPTH; i++) line_mem[i] = '0;
      for (i = 0; i < MAX_TAPS; i++) begin
         tap_dly[i] = '0;
         tap_gn[i]  = '0;
      end
      wr_pos   = 0;
      cfg_taps = 0;
      cfg_len  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_directed();
      test_random_phases();

      // drain, then give the pipe time to show any stray response
      settle();
      repeat (TAIL) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
design/mtdl_pkg.sv
design/multi_tap_delay_line.sv
tb/multi_tap_delay_line_test.sv
